>>> rtl/core/bpa_pkg.sv
// Package with constants, record layout and helpers of the buddy page allocator.
package bpa_pkg;

  localparam int MAX_RANK   = 16;
  localparam int POOL_DEPTH = 65536;

  localparam int PAGE_W = 52;
  localparam int POOL_W = 17;
  localparam int RANK_W = 5;
  localparam int CNT_W  = 17;
  localparam int STAT_W = 2;
  localparam int MODE_W = 2;

  localparam int OFF_W  = $clog2(POOL_DEPTH);
  localparam int SIZE_W = $clog2(POOL_DEPTH + 1);
  localparam int OFS_W  = ((SIZE_W > MAX_RANK) ? SIZE_W : MAX_RANK) + 1;
  localparam int CIDX_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int FIDX_W = $clog2(MAX_RANK + 1);

  localparam int REC_W     = 7;
  localparam int REC_START = 6;
  localparam int REC_USED  = 5;

  typedef logic [REC_W-1:0] rec_t;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;

  // Pages covered by a block of rank r.
  function automatic logic [OFS_W-1:0] block_size(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] sh;
    sh = r - RANK_W'(1);
    return OFS_W'(1) << sh;
  endfunction

  function automatic rec_t make_rec(input logic used, input logic [RANK_W-1:0] r);
    rec_t e;
    e = '0;
    e[REC_START] = 1'b1;
    e[REC_USED]  = used;
    e[RANK_W-1:0] = r;
    return e;
  endfunction

endpackage

>>> rtl/core/bpa_rec_ram.sv
// Page record memory: one write port and one registered read port.
module bpa_rec_ram
  import bpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [OFF_W-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic             re_i,
  input  logic [OFF_W-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem [POOL_DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/buddy_page_allocator_unit.sv
// Top level of the buddy page allocator: sequencer, counters and result register.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, mode_i, rank_i, page_i | request in
//  out     | out_valid_o, out_stall_i, status_o, page_out_o,| result out
//          | rank_out_o, count_out_o                        |
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i              | write only
//
// Every record read goes through the single read port of the page record memory.
// Count answers from the counters, query reads a record per rank, free reads the
// freed record and then its buddies, and allocate walks the block starts of the pool
// and then searches and splits.
// After reset and after each register write a rebuild pass writes all POOL_DEPTH
// records, one per cycle, with in_stall_o high.
// in_stall_o is high whenever a request is in work; a result waits in the output
// register while out_stall_i is high.
module buddy_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [RANK_W-1:0] rank_i,
  input  logic [PAGE_W-1:0] page_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [PAGE_W-1:0] page_out_o,
  output logic [RANK_W-1:0] rank_out_o,
  output logic [CNT_W-1:0]  count_out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [PAGE_W-1:0] cfg_data_i
);

  typedef enum logic [16:0] {
    S_INIT    = 17'h00001,
    S_SWEEP   = 17'h00002,
    S_IDLE    = 17'h00004,
    S_A_RD    = 17'h00008,
    S_A_EV    = 17'h00010,
    S_A_SEL   = 17'h00020,
    S_A_SPLIT = 17'h00040,
    S_A_FIN   = 17'h00080,
    S_F_RD    = 17'h00100,
    S_F_EV    = 17'h00200,
    S_F_BRD   = 17'h00400,
    S_F_BEV   = 17'h00800,
    S_F_FIN   = 17'h01000,
    S_Q_RD    = 17'h02000,
    S_Q_EV    = 17'h04000,
    S_DONE    = 17'h08000,
    S_SPARE   = 17'h10000
  } state_e;

  typedef struct packed {
    logic              inc;
    logic              dec;
    logic [CIDX_W-1:0] idx;
  } cnt_op_t;

  state_e state_q, state_d;

  logic [PAGE_W-1:0] base_q;
  logic [POOL_W-1:0] pool_q;
  logic [OFS_W-1:0]  psz_q, rem_q, nxt_q, off_q;
  logic [RANK_W-1:0] rank_q, r_q, i_q;
  logic [MAX_RANK:0] found_q;
  logic [OFF_W-1:0]  first_q [MAX_RANK+1];
  logic [CNT_W-1:0]  cnt_q [MAX_RANK];
  logic              cnt_clr;
  cnt_op_t           cnt_op;

  logic [STAT_W-1:0] res_status_q;
  logic [PAGE_W-1:0] res_page_q;
  logic [RANK_W-1:0] res_rank_q;
  logic [CNT_W-1:0]  res_count_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [PAGE_W-1:0] page_out_q;
  logic [RANK_W-1:0] rank_out_q;
  logic [CNT_W-1:0]  count_out_q;

  logic              mem_we, mem_re;
  logic [OFF_W-1:0]  mem_waddr, mem_raddr;
  rec_t              mem_wdata, rd;

  logic [PAGE_W-1:0] d_off;
  logic              d_ok, rank_ok, accept, out_load;
  logic [RANK_W-1:0] rd_rank, greedy_rank;
  logic [OFS_W-1:0]  bud, cur_size, pool_min;
  logic [31:0]       pool_ext;

  bpa_rec_ram u_rec (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign d_off    = page_i - base_q;
  assign d_ok     = d_off < PAGE_W'(psz_q);
  assign rank_ok  = (rank_i >= RANK_W'(1)) && (rank_i <= RANK_W'(MAX_RANK));
  assign rd_rank  = rd[RANK_W-1:0];
  assign cur_size = block_size(r_q);
  assign bud      = off_q ^ cur_size;
  assign pool_ext = 32'(pool_q);
  assign pool_min = (pool_ext > 32'(POOL_DEPTH)) ? OFS_W'(POOL_DEPTH) : OFS_W'(pool_q);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Rank of the next greedy block: the largest rank if it fits, else the top bit left.
  always_comb begin
    greedy_rank = '0;
    for (int b = 0; b < OFS_W; b++) begin
      if (rem_q[b]) begin
        greedy_rank = RANK_W'(b + 1);
      end
    end
    if (rem_q >= block_size(RANK_W'(MAX_RANK))) begin
      greedy_rank = RANK_W'(MAX_RANK);
    end
  end

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = off_q[OFF_W-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = off_q[OFF_W-1:0];
    cnt_op    = '0;
    cnt_clr   = 1'b0;
    case (state_q)
      S_INIT: begin
        cnt_clr = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        mem_we = 1'b1;
        if (rem_q != '0 && off_q == nxt_q) begin
          mem_wdata  = make_rec(1'b0, greedy_rank);
          cnt_op.inc = 1'b1;
          cnt_op.idx = CIDX_W'(greedy_rank - RANK_W'(1));
        end
        if (off_q == OFS_W'(POOL_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_ALLOC: state_d = rank_ok ? S_A_RD : S_DONE;
            MODE_FREE:  state_d = d_ok ? S_F_RD : S_DONE;
            MODE_QUERY: state_d = d_ok ? S_Q_RD : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_A_RD: begin
        if (off_q >= psz_q) begin
          state_d = S_A_SEL;
        end else begin
          mem_re  = 1'b1;
          state_d = S_A_EV;
        end
      end
      S_A_EV: state_d = S_A_RD;
      S_A_SEL: begin
        if (i_q > RANK_W'(MAX_RANK)) begin
          state_d = S_DONE;
        end else if (found_q[FIDX_W'(i_q)]) begin
          cnt_op.dec = 1'b1;
          cnt_op.idx = CIDX_W'(i_q - RANK_W'(1));
          state_d    = S_A_SPLIT;
        end
      end
      S_A_SPLIT: begin
        if (r_q < rank_q) begin
          state_d = S_A_FIN;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = OFF_W'(off_q + cur_size);
          mem_wdata  = make_rec(1'b0, r_q);
          cnt_op.inc = 1'b1;
          cnt_op.idx = CIDX_W'(r_q - RANK_W'(1));
        end
      end
      S_A_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = make_rec(1'b1, rank_q);
        state_d   = S_DONE;
      end
      S_F_RD: begin
        mem_re  = 1'b1;
        state_d = S_F_EV;
      end
      S_F_EV: begin
        if (!rd[REC_START] || !rd[REC_USED] || rd_rank < RANK_W'(1) ||
            rd_rank > RANK_W'(MAX_RANK)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_F_BRD;
        end
      end
      S_F_BRD: begin
        if (r_q >= RANK_W'(MAX_RANK) || bud >= psz_q) begin
          state_d = S_F_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = bud[OFF_W-1:0];
          state_d   = S_F_BEV;
        end
      end
      S_F_BEV: begin
        if (rd == make_rec(1'b0, r_q)) begin
          // The lower of the pair stays as the merged block; clear the upper start.
          mem_we     = 1'b1;
          mem_waddr  = (bud > off_q) ? bud[OFF_W-1:0] : off_q[OFF_W-1:0];
          cnt_op.dec = 1'b1;
          cnt_op.idx = CIDX_W'(r_q - RANK_W'(1));
          state_d    = S_F_BRD;
        end else begin
          state_d = S_F_FIN;
        end
      end
      S_F_FIN: begin
        mem_we     = 1'b1;
        mem_wdata  = make_rec(1'b0, r_q);
        cnt_op.inc = 1'b1;
        cnt_op.idx = CIDX_W'(r_q - RANK_W'(1));
        state_d    = S_DONE;
      end
      S_Q_RD: begin
        if (r_q > RANK_W'(MAX_RANK)) begin
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = OFF_W'(off_q & ~(cur_size - OFS_W'(1)));
          state_d   = S_Q_EV;
        end
      end
      S_Q_EV: begin
        state_d = (rd[REC_START] && rd_rank == r_q) ? S_DONE : S_Q_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      base_q  <= '0;
      pool_q  <= POOL_W'(65536);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          pool_q <= cfg_data_i[POOL_W-1:0];
        end else begin
          base_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cnt_clr) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cnt_op.inc) begin
      cnt_q[cnt_op.idx] <= cnt_q[cnt_op.idx] + CNT_W'(1);
    end else if (cnt_op.dec) begin
      cnt_q[cnt_op.idx] <= cnt_q[cnt_op.idx] - CNT_W'(1);
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_INIT: begin
        psz_q <= pool_min;
        rem_q <= pool_min;
        nxt_q <= '0;
        off_q <= '0;
      end
      S_SWEEP: begin
        if (rem_q != '0 && off_q == nxt_q) begin
          nxt_q <= nxt_q + block_size(greedy_rank);
          rem_q <= rem_q - block_size(greedy_rank);
        end
        off_q <= off_q + OFS_W'(1);
      end
      S_IDLE: begin
        res_status_q <= STAT_OK;
        res_page_q   <= '0;
        res_rank_q   <= '0;
        res_count_q  <= '0;
        rank_q       <= rank_i;
        i_q          <= rank_i;
        found_q      <= '0;
        off_q        <= '0;
        r_q          <= RANK_W'(1);
        if (accept) begin
          case (mode_i)
            MODE_ALLOC: begin
              if (!rank_ok) res_status_q <= STAT_INVALID;
            end
            MODE_FREE, MODE_QUERY: begin
              off_q <= OFS_W'(d_off[OFF_W-1:0]);
              if (!d_ok) res_status_q <= STAT_INVALID;
            end
            default: begin
              if (!rank_ok) begin
                res_status_q <= STAT_INVALID;
              end else begin
                res_count_q <= cnt_q[CIDX_W'(rank_i - RANK_W'(1))];
              end
            end
          endcase
        end
      end
      S_A_EV: begin
        if (!rd[REC_START] || rd_rank < RANK_W'(1) || rd_rank > RANK_W'(MAX_RANK)) begin
          off_q <= off_q + OFS_W'(1);
        end else begin
          if (!rd[REC_USED] && !found_q[FIDX_W'(rd_rank)]) begin
            found_q[FIDX_W'(rd_rank)] <= 1'b1;
            first_q[FIDX_W'(rd_rank)] <= off_q[OFF_W-1:0];
          end
          off_q <= off_q + block_size(rd_rank);
        end
      end
      S_A_SEL: begin
        if (i_q > RANK_W'(MAX_RANK)) begin
          res_status_q <= STAT_NOSPACE;
        end else if (found_q[FIDX_W'(i_q)]) begin
          off_q <= OFS_W'(first_q[FIDX_W'(i_q)]);
          r_q   <= i_q - RANK_W'(1);
        end else begin
          i_q <= i_q + RANK_W'(1);
        end
      end
      S_A_SPLIT: begin
        if (r_q >= rank_q) begin
          r_q <= r_q - RANK_W'(1);
        end
      end
      S_A_FIN: res_page_q <= base_q + PAGE_W'(off_q);
      S_F_EV: begin
        r_q <= rd_rank;
        if (!rd[REC_START] || !rd[REC_USED] || rd_rank < RANK_W'(1) ||
            rd_rank > RANK_W'(MAX_RANK)) begin
          res_status_q <= STAT_INVALID;
        end
      end
      S_F_BEV: begin
        if (rd == make_rec(1'b0, r_q)) begin
          if (bud < off_q) off_q <= bud;
          r_q <= r_q + RANK_W'(1);
        end
      end
      S_Q_RD: begin
        if (r_q > RANK_W'(MAX_RANK)) res_status_q <= STAT_INVALID;
      end
      S_Q_EV: begin
        if (rd[REC_START] && rd_rank == r_q) begin
          res_rank_q <= r_q;
        end else begin
          r_q <= r_q + RANK_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q    <= res_status_q;
      page_out_q  <= res_page_q;
      rank_out_q  <= res_rank_q;
      count_out_q <= res_count_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign page_out_o  = page_out_q;
  assign rank_out_o  = rank_out_q;
  assign count_out_o = count_out_q;

endmodule
